/* sv/dhs_pkg.sv */
package dhs_pkg;

    // table geometry, table_slots must be a power of two
    localparam int unsigned TABLE_SLOTS = 4096;
    localparam int unsigned PROBE_LIMIT = 3;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int unsigned PROBE_W     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    localparam int unsigned KEY_W       = 32;
    localparam int unsigned SLOT_FIELD_W = 12;
    localparam int unsigned COUNT_W     = 16;

    // key zero is kept under this code, a stored zero means empty
    localparam logic [KEY_W-1:0] ZERO_KEY_CODE = 32'h8000_0000;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 32;

    // one table entry: logged mark above the stored key
    typedef struct packed {
        logic             mark;
        logic [KEY_W-1:0] key;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

endpackage

/* sv/dedup_hash_set_with_logged_marks_top.sv */
// channel  | dir | signals                          | tdata fields, lowest bit first
// ---------+-----+----------------------------------+--------------------------------------
// s_axis   | in  | s_tvalid, s_tready, s_tdata[39:0] | key[31:0], sink_ready[32], zero pad
// m_axis   | out | m_tvalid, m_tready, m_tdata[31:0] | first_seen, needs_row, located,
//          |     |                                  | slot_index[14:3], marked_logged[15],
//          |     |                                  | new_device_count[31:16]
//
// an item probes its slots one at a time, up to 3 of them, as the table ram has a
// single read port and a registered read
// the write-back of an item overlaps the home read of the next item, a
// one-entry forward register covers a read of the slot just written
// after reset the table is swept to zero, all 4096 slots, with s_tready low
// a result waits in the output register; with it full and m_tready low the
// deciding probe is read again each cycle and no new item is taken
module dedup_hash_set_with_logged_marks_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dhs_pkg::IN_DATA_W-1:0]   s_tdata,   // key, sink_ready, pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dhs_pkg::OUT_DATA_W-1:0]  m_tdata    // first_seen, needs_row, located,
                                                       // slot_index, marked_logged,
                                                       // new_device_count
);

    dhs_pkg::state_t state_reg, state_next;

    // item under probe
    logic [dhs_pkg::KEY_W-1:0]   stored_reg;
    logic                        ready_reg;
    logic [dhs_pkg::SLOT_W-1:0]  addr_reg;
    logic [dhs_pkg::PROBE_W-1:0] probe_cnt_reg;

    // clearing sweep
    logic [dhs_pkg::SLOT_W-1:0]  clr_addr_reg;

    // first-sighting count
    logic [dhs_pkg::COUNT_W-1:0] count_reg, count_next;

    // forward of the last item write
    logic                        fwd_valid_reg;
    logic [dhs_pkg::SLOT_W-1:0]  fwd_addr_reg;
    dhs_pkg::entry_t             fwd_data_reg;

    // output register
    logic                             out_valid_reg;
    logic [dhs_pkg::OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    // ram port signals
    logic                        ram_we;
    logic [dhs_pkg::SLOT_W-1:0]  ram_waddr;
    dhs_pkg::entry_t             ram_wdata;
    logic                        ram_re;
    logic [dhs_pkg::SLOT_W-1:0]  ram_raddr;
    dhs_pkg::entry_t             ram_rdata;

    // incoming item fields
    logic [dhs_pkg::KEY_W-1:0]   in_key;
    logic                        in_sink_ready;
    logic [dhs_pkg::KEY_W-1:0]   in_stored;
    logic [dhs_pkg::SLOT_W-1:0]  in_home;

    // probe decision
    logic            busy;
    logic            s_fire;
    logic            out_free;
    dhs_pkg::entry_t rd_entry;
    logic            slot_empty;
    logic            slot_match;
    logic            slot_hit;
    logic            last_probe;
    logic            decide;
    logic            advance;
    logic            finish;
    logic            stall;
    logic            need_row;
    logic            mark_set;

    dhs_ram #(
        .WIDTH (dhs_pkg::ENTRY_W),
        .DEPTH (dhs_pkg::TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_key        = s_tdata[dhs_pkg::KEY_W-1:0];
    assign in_sink_ready = s_tdata[dhs_pkg::KEY_W];
    assign in_stored     = (in_key == '0) ? dhs_pkg::ZERO_KEY_CODE : in_key;
    // home slot is key mod table size
    assign in_home       = in_key[dhs_pkg::SLOT_W-1:0];

    assign busy     = (state_reg == dhs_pkg::ST_PROBE);
    assign out_free = !out_valid_reg || m_tready;

    // slot data as of now, covering a write made in the cycle of the read
    assign rd_entry   = (fwd_valid_reg && (fwd_addr_reg == addr_reg)) ? fwd_data_reg
                                                                       : ram_rdata;
    assign slot_empty = (rd_entry.key == '0);
    assign slot_match = (rd_entry.key == stored_reg);
    assign slot_hit   = slot_empty || slot_match;
    assign last_probe = (probe_cnt_reg == dhs_pkg::PROBE_W'(dhs_pkg::PROBE_LIMIT - 1));

    assign decide  = busy && (slot_hit || last_probe);
    assign advance = busy && !slot_hit && !last_probe;
    assign finish  = decide && out_free;
    assign stall   = decide && !out_free;

    assign need_row = slot_empty || (slot_match && !rd_entry.mark);
    assign mark_set = slot_hit && need_row && ready_reg;

    assign s_fire = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dhs_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == dhs_pkg::SLOT_W'(dhs_pkg::TABLE_SLOTS - 1))
                begin
                    state_next = dhs_pkg::ST_IDLE;
                end
            end
            dhs_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = dhs_pkg::ST_PROBE;
                end
            end
            dhs_pkg::ST_PROBE:
            begin
                if (finish && !s_fire)
                begin
                    state_next = dhs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dhs_pkg::ST_CLEAR;
            end
        endcase
    end

    // handshake and ram controls
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '{mark: rd_entry.mark || mark_set, key: stored_reg};
        ram_re    = 1'b0;
        ram_raddr = addr_reg;
        case (state_reg)
            dhs_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            dhs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            dhs_pkg::ST_PROBE:
            begin
                s_tready = finish;
                ram_we   = finish && slot_hit;
                if (advance)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + 1'b1;
                end
                else if (stall)
                begin
                    ram_re = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        if (s_fire)
        begin
            ram_re    = 1'b1;
            ram_raddr = in_home;
        end
    end

    // result fields
    always_comb
    begin
        count_next    = count_reg + dhs_pkg::COUNT_W'(slot_empty);
        out_data_next = {count_next,
                         mark_set,
                         slot_hit ? dhs_pkg::SLOT_FIELD_W'(addr_reg)
                                  : {dhs_pkg::SLOT_FIELD_W{1'b0}},
                         slot_hit,
                         slot_hit && need_row,
                         slot_empty};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhs_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dhs_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (finish)
            begin
                count_reg <= count_next;
            end
            fwd_valid_reg <= finish && slot_hit;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            stored_reg    <= in_stored;
            ready_reg     <= in_sink_ready;
            addr_reg      <= in_home;
            probe_cnt_reg <= '0;
        end
        else if (advance)
        begin
            addr_reg      <= addr_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
        if (finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a stored key is never the empty code
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && busy) |-> (ram_wdata.key != '0))
        else $error("item write stores an empty key");

    // the count moves only on a first sighting
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(finish && slot_empty))
        else $error("device count changed without a first sighting");

    // probing never runs past the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (probe_cnt_reg <= dhs_pkg::PROBE_W'(dhs_pkg::PROBE_LIMIT - 1)))
        else $error("probe count beyond limit");

    // a new item always starts by reading its home slot
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |-> (ram_re && (ram_raddr == in_home)))
        else $error("accepted item did not read its home slot");

    // a result is only produced while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(busy))
        else $error("result appeared without an item");

endmodule

/* sv/dhs_ram.sv */
module dhs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // result item as it sits on m_tdata, first_seen in bit 0
    typedef struct packed {
        logic [dhs_pkg::COUNT_W-1:0]      new_device_count;
        logic                             marked_logged;
        logic [dhs_pkg::SLOT_FIELD_W-1:0] slot_index;
        logic                             located;
        logic                             needs_row;
        logic                             first_seen;
    } lookup_result_t;

    localparam int unsigned RUN_CYCLE_LIMIT = 400_000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned KEY_HISTORY_MAX = 256;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // stream ports; the inputs of the block are driven to known values from time zero
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dhs_pkg::IN_DATA_W-1:0]  s_tdata  = '0;   // key[31:0], sink_ready[32], zero pad
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dhs_pkg::OUT_DATA_W-1:0] m_tdata;         // first_seen, needs_row, located,
                                                     // slot_index, marked_logged,
                                                     // new_device_count

    // shadow copy of the dedup table used for prediction
    logic [dhs_pkg::KEY_W-1:0]   shadow_keys  [dhs_pkg::TABLE_SLOTS];
    bit                          shadow_marks [dhs_pkg::TABLE_SLOTS];
    logic [dhs_pkg::COUNT_W-1:0] shadow_sightings;

    // lookups still owed by the block, oldest first
    lookup_result_t pending_lookups [$];

    // keys already sent, reused so that matches and mark updates happen often
    logic [dhs_pkg::KEY_W-1:0] key_history [$];

    // idle and stall rates of the current phase, in percent
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off, requested by a test and counted by the receiver
    int unsigned holdoff_request = 0;
    int unsigned holdoff_left    = 0;

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned inserts_seen  = 0;
    int unsigned drops_seen    = 0;
    int unsigned marks_seen    = 0;
    int unsigned refused_marks = 0;

    dedup_hash_set_with_logged_marks_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // predict one lookup and update the shadow table the way the block should
    function automatic lookup_result_t probe_and_update(
        input logic [dhs_pkg::KEY_W-1:0] key,
        input logic                      sink_ready
    );
        lookup_result_t            res;
        logic [dhs_pkg::KEY_W-1:0] stored;
        int unsigned               home;
        int unsigned               idx;
        bit                        decided;
        res     = '0;
        // zero marks an empty slot, so key zero lives under its own code
        stored  = (key == '0) ? dhs_pkg::ZERO_KEY_CODE : key;
        home    = key % dhs_pkg::TABLE_SLOTS;
        idx     = home;
        decided = 1'b0;
        for (int unsigned p = 0; p < dhs_pkg::PROBE_LIMIT && !decided; p++)
        begin
            idx = (home + p) % dhs_pkg::TABLE_SLOTS;
            if (shadow_keys[idx] == '0)
            begin
                shadow_keys[idx] = stored;
                res.first_seen   = 1'b1;
                res.needs_row    = 1'b1;
                res.located      = 1'b1;
                decided          = 1'b1;
            end
            else if (shadow_keys[idx] == stored)
            begin
                res.needs_row = !shadow_marks[idx];
                res.located   = 1'b1;
                decided       = 1'b1;
            end
        end
        if (res.located)
            res.slot_index = idx[dhs_pkg::SLOT_FIELD_W-1:0];
        if (res.first_seen)
            shadow_sightings = shadow_sightings + 1'b1;
        // the mark is only set when the row sink takes the row
        if (res.located && res.needs_row && sink_ready)
        begin
            shadow_marks[idx] = 1'b1;
            res.marked_logged = 1'b1;
        end
        res.new_device_count = shadow_sightings;
        return res;
    endfunction

    // random key: reuse, crowded home slots, full range, or an alias corner
    function automatic logic [dhs_pkg::KEY_W-1:0] pick_key();
        logic [dhs_pkg::KEY_W-1:0] key;
        int unsigned               r;
        r = $urandom_range(99);
        if (r < 35 && key_history.size() != 0)
            key = key_history[$urandom_range(key_history.size() - 1)];
        else if (r < 70)
        begin
            // few high parts per home slot, so runs of slots fill and probes miss
            key = dhs_pkg::KEY_W'($urandom_range(7)) << 12;
            if ($urandom_range(3) == 0)
                key[dhs_pkg::KEY_W-1:dhs_pkg::KEY_W-4] = 4'($urandom_range(15));
            if ($urandom_range(1) == 0)
                key[11:0] = 12'($urandom_range(31));
            else
                key[11:0] = 12'hfff - 12'($urandom_range(7));
        end
        else if (r < 92)
            key = $urandom;
        else
        begin
            case ($urandom_range(3))
                0:       key = '0;
                1:       key = dhs_pkg::ZERO_KEY_CODE;
                2:       key = '1;
                default: key = 32'hffff_f000;
            endcase
        end
        if (key_history.size() >= KEY_HISTORY_MAX)
            void'(key_history.pop_front());
        key_history.push_back(key);
        return key;
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_lookup(input logic [dhs_pkg::KEY_W-1:0] key,
                               input logic sink_ready);
        lookup_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(dhs_pkg::IN_DATA_W - dhs_pkg::KEY_W - 1){1'b0}}, sink_ready, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = probe_and_update(key, sink_ready);
        pending_lookups.push_back(want);
        items_sent++;
        if (want.first_seen)
            inserts_seen++;
        if (!want.located)
            drops_seen++;
        if (want.marked_logged)
            marks_seen++;
        if (want.needs_row && !sink_ready)
            refused_marks++;
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    // corners: key zero and its alias, wrap at the table end, probe misses,
    // sink refusing a row, extreme keys
    task automatic run_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_lookup(32'h0000_0000, 1'b0);   // insert at slot 0, row refused
        send_lookup(32'h8000_0000, 1'b1);   // alias of key zero, marked now
        send_lookup(32'h0000_0000, 1'b1);   // already logged
        send_lookup(32'hffff_ffff, 1'b1);   // home is the last slot
        send_lookup(32'h0000_0fff, 1'b0);   // wraps past slot 0 into slot 1
        send_lookup(32'h0000_1fff, 1'b1);   // all three probes taken, dropped
        send_lookup(32'h0000_2fff, 1'b1);   // dropped as well
        send_lookup(32'h0000_0fff, 1'b1);   // asks again, marked now
        send_lookup(32'h0000_0fff, 1'b1);
        send_lookup(32'h0000_0005, 1'b1);
        send_lookup(32'h0000_1005, 1'b1);
        send_lookup(32'h0000_2005, 1'b0);
        send_lookup(32'h0000_3005, 1'b1);   // dropped
        send_lookup(32'h0000_3005, 1'b0);   // dropped again
        send_lookup(32'h0000_2005, 1'b1);   // match on the last probe
        send_lookup(32'h0000_0006, 1'b0);   // home taken by a neighbor's run
        send_lookup(32'haaaa_aaaa, 1'b1);
        send_lookup(32'h5555_5555, 1'b0);
        send_lookup(32'h5555_5555, 1'b1);
        send_lookup(32'h7fff_ffff, 1'b1);
        send_lookup(32'h8000_0001, 1'b0);
        send_lookup(32'hffff_ffff, 1'b1);
        wait_drained();
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned n_items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items)
            send_lookup(pick_key(), 1'($urandom_range(1)));
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // the block fills and must drop s_tready
    task automatic run_holdoff_fill();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        holdoff_request = 300;
        repeat (30)
            send_lookup(pick_key(), 1'($urandom_range(1)));
        wait_drained();
    endtask

    // receiver side: random stalls, or a counted hold-off when one is asked
    always @(posedge clk)
    begin
        if (holdoff_request != 0)
        begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result taken with the oldest owed lookup
    always @(posedge clk)
    begin
        lookup_result_t got;
        lookup_result_t want;
        if (m_tvalid && m_tready)
        begin
            got = lookup_result_t'(m_tdata);
            results_seen++;
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item %h at cycle %0d", m_tdata, cycle_count);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch at result %0d: first/needs/located/slot/marked/count",
                                 results_seen);
                        $display("  expected %b %b %b %0d %b %0d",
                                 want.first_seen, want.needs_row, want.located,
                                 want.slot_index, want.marked_logged,
                                 want.new_device_count);
                        $display("  got      %b %b %b %0d %b %0d",
                                 got.first_seen, got.needs_row, got.located,
                                 got.slot_index, got.marked_logged,
                                 got.new_device_count);
                    end
                end
            end
        end
    end

    // watchdog, covers the clearing sweep after reset with a wide margin
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     pending_lookups.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_keys[i])
        begin
            shadow_keys[i]  = '0;
            shadow_marks[i] = 1'b0;
        end
        shadow_sightings = '0;

        // one reset at the start, the block then sweeps its table with s_tready low
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed_cases();
        run_random_phase(0, 0, 400);
        run_random_phase(66, 0, 400);
        run_random_phase(0, 66, 400);
        run_holdoff_fill();
        run_random_phase(7, 7, 400);

        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d lookups and %0d results: %0d inserts, %0d dropped on probe miss,",
                 items_sent, results_seen, inserts_seen, drops_seen);
        $display("%0d marks set, %0d rows refused by the sink, %0d mismatches",
                 marks_seen, refused_marks, mismatches);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* dedup_hash_set_with_logged_marks_top.f */
sv/dhs_pkg.sv
sv/dhs_ram.sv
sv/dedup_hash_set_with_logged_marks_top.sv
tb/sv/testbench.sv
